/* src/jpld_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the JTAG loopback pattern detector.
package jpld_pkg;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_PATTERN = 2'd0,
    REG_PATLEN  = 2'd1,
    REG_ITER    = 2'd2
  } reg_idx_t;

  localparam int PATTERN_W  = 64;
  localparam int PATLEN_W   = 7;
  localparam int CNT_W      = 12;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 32;

  localparam logic [PATTERN_W-1:0] PATTERN_RESET = 64'd9907319526;
  localparam logic [PATLEN_W-1:0]  PATLEN_RESET  = 7'd34;
  localparam logic [CNT_W-1:0]     ITER_RESET    = 12'd128;
  localparam logic [PATLEN_W-1:0]  PATLEN_MAX    = 7'd64;

  // One result beat
  typedef struct packed {
    logic             tdi_next;
    logic             done_res;
    logic             found;
    logic [CNT_W-1:0] register_length;
    logic [CNT_W-1:0] toggle_count;
  } res_t;

endpackage

/* src/jtag_pattern_loopback_detector_core.sv */
`timescale 1ns / 1ps
// Top level: JTAG loopback pattern detector with input and result registers.
//
// Usage:
//   Input stream (in_*): one beat per TCK cycle. in_tuser is start_req, which
//   opens a new check and gives the TDO level before the first clock;
//   in_tdata[0] is the TDO level sampled after the current clock.
//   Result stream (out_*): exactly one beat for every input beat, in order.
//   out_tdata[0] is the TDI bit to drive on the next clock; out_tlast marks the
//   beat that ends the check (match or timeout), with found, the shift-register
//   length and the TDO toggle count in the upper tdata bits.
//   Config port (cfg_*): write pattern, pattern length and iteration limit
//   while the block is idle; writes take effect on the next clock.
// Timing:
//   An accepted input beat is held in the input register, then loaded into the
//   result register that drives out_tvalid. Compare, counters and state update
//   sit in one combinational step between the two: one beat per cycle while
//   out_tready is high. A stalled receiver holds the result register; the input
//   register takes one more beat, then in_tready drops until out_tready returns.
// Reset: rst_n (synchronous, active low) empties both stages, clears the
//   detector state to idle and loads the default pattern, length 34, limit 128.
module jtag_pattern_loopback_detector_core import jpld_pkg::*; #(
  parameter int WINDOW_BITS = 64
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // input stream
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [0] tdo, [7:1] zero
  input  logic                   in_tuser,   // [0] start_req
  // result stream
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [0] tdi_next, [1] found,
                                             // [13:2] register_length,
                                             // [25:14] toggle_count, [31:26] zero
  output logic                   out_tlast,  // done_res
  // config write port
  input  logic                   cfg_we,
  input  logic [1:0]             cfg_addr,
  input  logic [PATTERN_W-1:0]   cfg_wdata
);

  localparam int IDX_W = $clog2(WINDOW_BITS);
  localparam logic [PATLEN_W-1:0] WIN_LEN = PATLEN_W'(WINDOW_BITS);

  // Config registers
  logic [PATTERN_W-1:0] pattern_r;
  logic [PATLEN_W-1:0]  patlen_r;
  logic [CNT_W-1:0]     iter_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_r <= PATTERN_RESET;
      patlen_r  <= PATLEN_RESET;
      iter_r    <= ITER_RESET;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_addr))
        REG_PATTERN: pattern_r <= cfg_wdata;
        REG_PATLEN:  patlen_r  <= cfg_wdata[PATLEN_W-1:0];
        REG_ITER:    iter_r    <= cfg_wdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake / stage control
  logic s1_valid_r, s1_start_r, s1_tdo_r;
  logic out_valid_r;
  res_t res_r, res_nxt;
  logic adv, in_fire, load_out;

  assign adv       = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || adv;
  assign in_fire   = in_tvalid && in_tready;
  assign load_out  = s1_valid_r && adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire)  s1_valid_r <= 1'b1;
      else if (adv) s1_valid_r <= 1'b0;
      if (adv) out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_start_r <= in_tuser;
      s1_tdo_r   <= in_tdata[0];
    end
    if (load_out) res_r <= res_nxt;
  end

  // Detector state
  logic [WINDOW_BITS-1:0] window_r, window_nxt;
  logic [IDX_W-1:0]       bit_index_r, bit_index_nxt;
  logic [CNT_W-1:0]       sample_count_r, sample_count_nxt;
  logic [CNT_W-1:0]       toggles_r, toggles_nxt;
  logic                   last_tdo_r, last_tdo_nxt;
  logic                   active_r, active_nxt;

  // Effective pattern length: 0 counts as 1, clipped to 64 and to the window
  logic [PATLEN_W-1:0]    len_clip, eff_len;
  logic [WINDOW_BITS-1:0] len_mask, shifted, pat_masked;
  logic [PATLEN_W-1:0]    bit_inc;
  logic [CNT_W:0]         samp_inc;
  logic [5:0]             pat_idx;

  always_comb begin
    len_clip = patlen_r;
    if (patlen_r == '0)         len_clip = 7'd1;
    if (patlen_r > PATLEN_MAX)  len_clip = PATLEN_MAX;
    eff_len = (len_clip > WIN_LEN) ? WIN_LEN : len_clip;
    len_mask = (eff_len >= WIN_LEN) ? '1
             : ((WINDOW_BITS'(1) << eff_len) - WINDOW_BITS'(1));
    pat_masked = pattern_r[WINDOW_BITS-1:0] & len_mask;
  end

  always_comb begin
    window_nxt       = window_r;
    bit_index_nxt    = bit_index_r;
    sample_count_nxt = sample_count_r;
    toggles_nxt      = toggles_r;
    last_tdo_nxt     = last_tdo_r;
    active_nxt       = active_r;
    res_nxt          = '0;
    bit_inc  = PATLEN_W'(bit_index_r) + 7'd1;
    samp_inc = {1'b0, sample_count_r} + 13'd1;
    shifted  = ((window_r & len_mask) >> 1)
             | (WINDOW_BITS'(s1_tdo_r) << (eff_len - 7'd1));
    pat_idx  = 6'(bit_index_r);

    if (s1_start_r) begin
      window_nxt       = '0;
      bit_index_nxt    = '0;
      sample_count_nxt = '0;
      toggles_nxt      = '0;
      last_tdo_nxt     = s1_tdo_r;
      if (iter_r == '0) begin
        // zero limit: immediate timeout
        active_nxt       = 1'b0;
        res_nxt.done_res = 1'b1;
      end else begin
        active_nxt       = 1'b1;
        res_nxt.tdi_next = pattern_r[0];
      end
    end else begin
      if (active_r) begin
        bit_index_nxt = (bit_inc >= eff_len) ? '0 : IDX_W'(bit_inc);
        if (s1_tdo_r != last_tdo_r) toggles_nxt = toggles_r + 12'd1;
        last_tdo_nxt     = s1_tdo_r;
        window_nxt       = shifted & len_mask;
        sample_count_nxt = samp_inc[CNT_W-1:0];
        if (samp_inc >= (CNT_W+1)'(eff_len) && window_nxt == pat_masked) begin
          res_nxt.done_res        = 1'b1;
          res_nxt.found           = 1'b1;
          res_nxt.register_length = CNT_W'(samp_inc - (CNT_W+1)'(eff_len));
          active_nxt              = 1'b0;
        end else if (samp_inc >= {1'b0, iter_r}) begin
          res_nxt.done_res     = 1'b1;
          res_nxt.toggle_count = (toggles_nxt > 12'd1) ? toggles_nxt : '0;
          active_nxt           = 1'b0;
        end
      end
      pat_idx          = 6'(bit_index_nxt);
      res_nxt.tdi_next = pattern_r[pat_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r       <= '0;
      bit_index_r    <= '0;
      sample_count_r <= '0;
      toggles_r      <= '0;
      last_tdo_r     <= 1'b0;
      active_r       <= 1'b0;
    end else if (load_out) begin
      window_r       <= window_nxt;
      bit_index_r    <= bit_index_nxt;
      sample_count_r <= sample_count_nxt;
      toggles_r      <= toggles_nxt;
      last_tdo_r     <= last_tdo_nxt;
      active_r       <= active_nxt;
    end
  end

  // Outputs
  assign out_tvalid = out_valid_r;
  assign out_tlast  = res_r.done_res;
  assign out_tdata  = {6'b0, res_r.toggle_count, res_r.register_length,
                       res_r.found, res_r.tdi_next};

  // Assertions
  a_done_idles: assert property (@(posedge clk) disable iff (!rst_n)
    (load_out && res_nxt.done_res) |=> !active_r)
    else $error("check ended but detector still active");

  a_found_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.found) |-> res_r.done_res)
    else $error("found reported without done");

  a_rlen_found: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.register_length != '0) |-> res_r.found)
    else $error("register length without a match");

  a_tcnt_timeout: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.toggle_count != '0) |-> (res_r.done_res && !res_r.found))
    else $error("toggle count outside a timeout");

  a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (load_out && s1_start_r) |=> (sample_count_r == '0 && toggles_r == '0))
    else $error("start did not clear counters");

endmodule
